[rtl/lsp_pkg.sv]
package lsp_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);

   localparam int CMD_W = 2;
   localparam int WORD_W = 32;
   localparam int PEEK_W = 5;
   localparam int STATUS_W = 2;
   localparam int CMP_W = (CNT_W > PEEK_W) ? CNT_W : PEEK_W;

   localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   localparam logic signed [WORD_W-1:0] ERR_WORD = -32'sd1;

   typedef logic signed [WORD_W-1:0] word_type;

   // controller to datapath
   typedef struct packed {
      logic exec;
   } cmd_type;

endpackage

[rtl/lsp_if.sv]
interface lsp_req_if;
   logic valid;
   logic ready;
   logic [lsp_pkg::CMD_W-1:0] command;
   lsp_pkg::word_type push_value;
   logic [lsp_pkg::PEEK_W-1:0] peek_depth;

   modport source(output valid, command, push_value, peek_depth, input ready);
   modport sink(input valid, command, push_value, peek_depth, output ready);
endinterface

interface lsp_rsp_if;
   logic valid;
   logic ready;
   lsp_pkg::word_type read_data;
   logic [lsp_pkg::STATUS_W-1:0] status;
   logic empty_flag;
   logic full_flag;

   modport source(output valid, read_data, status, empty_flag, full_flag, input ready);
   modport sink(input valid, read_data, status, empty_flag, full_flag, output ready);
endinterface

[rtl/lsp_ctrl.sv]
module lsp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lsp_pkg::cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SEND = 1'b1;

   logic state_ff;
   logic state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_SEND);
   assign cmd.exec = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.exec) state_in = S_SEND;
         end
         S_SEND: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

`ifndef NO_ASSERTIONS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");
   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid)
      else $error("accepted request produced no response");
`endif

endmodule

[rtl/lsp_dpath.sv]
module lsp_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  lsp_pkg::cmd_type                 cmd,
   input  logic [lsp_pkg::CMD_W-1:0]        command,
   input  lsp_pkg::word_type                push_value,
   input  logic [lsp_pkg::PEEK_W-1:0]       peek_depth,
   output lsp_pkg::word_type                read_data,
   output logic [lsp_pkg::STATUS_W-1:0]     status,
   output logic                             empty_flag,
   output logic                             full_flag
);

   lsp_pkg::word_type mem [lsp_pkg::DEPTH];

   logic [lsp_pkg::CNT_W-1:0] count_ff;
   logic [lsp_pkg::CNT_W-1:0] count_in;
   logic [lsp_pkg::STATUS_W-1:0] status_ff;
   logic [lsp_pkg::STATUS_W-1:0] status_in;
   lsp_pkg::word_type data_ff;
   lsp_pkg::word_type data_in;
   logic sel_mem_ff;
   logic sel_mem_in;
   lsp_pkg::word_type rd_q_ff;

   logic stack_empty;
   logic is_full;
   logic wr_en;
   logic [lsp_pkg::ADDR_W-1:0] rd_addr;
   logic [lsp_pkg::CMP_W-1:0] cnt_ext;
   logic [lsp_pkg::CMP_W-1:0] dep_ext;
   logic [lsp_pkg::CMP_W-1:0] peek_pos;
   logic [lsp_pkg::CNT_W-1:0] top_pos;

   assign stack_empty = (count_ff == '0);
   assign is_full = (count_ff == lsp_pkg::CNT_W'(lsp_pkg::DEPTH));
   assign cnt_ext = lsp_pkg::CMP_W'(count_ff);
   assign dep_ext = lsp_pkg::CMP_W'(peek_depth);
   assign peek_pos = cnt_ext - dep_ext;
   assign top_pos = count_ff - lsp_pkg::CNT_W'(1);

   always_comb begin
      count_in = count_ff;
      status_in = lsp_pkg::ST_OK;
      data_in = '0;
      sel_mem_in = 1'b0;
      wr_en = 1'b0;
      rd_addr = top_pos[lsp_pkg::ADDR_W-1:0];
      case (command)
         lsp_pkg::CMD_PUSH: begin
            if (is_full) begin
               status_in = lsp_pkg::ST_OVERFLOW;
            end else begin
               wr_en = 1'b1;
               count_in = count_ff + lsp_pkg::CNT_W'(1);
            end
         end
         lsp_pkg::CMD_POP: begin
            if (stack_empty) begin
               status_in = lsp_pkg::ST_UNDERFLOW;
               data_in = lsp_pkg::ERR_WORD;
            end else begin
               sel_mem_in = 1'b1;
               count_in = top_pos;
            end
         end
         lsp_pkg::CMD_PEEK: begin
            rd_addr = peek_pos[lsp_pkg::ADDR_W-1:0];
            if (dep_ext == '0 || dep_ext > cnt_ext) begin
               status_in = lsp_pkg::ST_RANGE;
               data_in = lsp_pkg::ERR_WORD;
            end else begin
               sel_mem_in = 1'b1;
            end
         end
         default: begin
            // unused code acts as a no-op
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (cmd.exec) count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         data_ff <= data_in;
         sel_mem_ff <= sel_mem_in;
      end
   end

   // push writes; every request reads, but only pop/peek use the read
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) mem[count_ff[lsp_pkg::ADDR_W-1:0]] <= push_value;
      if (cmd.exec) rd_q_ff <= mem[rd_addr];
   end

   assign read_data = sel_mem_ff ? rd_q_ff : data_ff;
   assign status = status_ff;
   assign empty_flag = stack_empty;
   assign full_flag = is_full;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lsp_pkg::CNT_W'(lsp_pkg::DEPTH))
      else $error("entry count beyond depth");
   a_underflow_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && command == lsp_pkg::CMD_POP && stack_empty |=> $stable(count_ff))
      else $error("pop on empty stack changed the count");
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && command == lsp_pkg::CMD_PUSH && !is_full
      |=> count_ff == $past(count_ff) + lsp_pkg::CNT_W'(1))
      else $error("push did not advance the count");
`endif

endmodule

[rtl/lifo_stack_with_peek.sv]
// response: valid in the cycle after the request is taken
// flow: one request at a time, the controller
//   holding off new requests until the response leaves its output register
// reset: synchronous active high, clears the entry count and the controller;
//   stack entries stay undefined until pushed
module lifo_stack_with_peek (
   input logic clock,
   input logic reset,
   lsp_req_if.sink req_if,
   lsp_rsp_if.source rsp_if
);

   lsp_pkg::cmd_type cmd;

   lsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   lsp_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .command    (req_if.command),
      .push_value (req_if.push_value),
      .peek_depth (req_if.peek_depth),
      .read_data  (rsp_if.read_data),
      .status     (rsp_if.status),
      .empty_flag (rsp_if.empty_flag),
      .full_flag  (rsp_if.full_flag)
   );

endmodule

[tb/lsp_checker.sv]
module lsp_checker (
   input logic clock,
   input logic reset,
   lsp_req_if req,
   lsp_rsp_if rsp,
   output int error_count,
   output int outstanding
);

   typedef struct packed {
      lsp_pkg::word_type read_data;
      logic [lsp_pkg::STATUS_W-1:0] status;
      logic empty_flag;
      logic full_flag;
   } stack_reply_type;

   lsp_pkg::word_type stack_words [lsp_pkg::DEPTH];
   int unsigned level = 0;
   stack_reply_type pending_replies [$];
   int fail_tally = 0;

   function automatic stack_reply_type apply_command(logic [lsp_pkg::CMD_W-1:0] command,
                                                     lsp_pkg::word_type value,
                                                     logic [lsp_pkg::PEEK_W-1:0] depth);
      stack_reply_type reply;
      reply.read_data = '0;
      reply.status = lsp_pkg::ST_OK;
      case (command)
         lsp_pkg::CMD_PUSH: begin
            if (level >= lsp_pkg::DEPTH) begin
               reply.status = lsp_pkg::ST_OVERFLOW;
            end else begin
               stack_words[lsp_pkg::ADDR_W'(level)] = value;
               level++;
            end
         end
         lsp_pkg::CMD_POP: begin
            if (level == 0) begin
               reply.status = lsp_pkg::ST_UNDERFLOW;
               reply.read_data = lsp_pkg::ERR_WORD;
            end else begin
               level--;
               reply.read_data = stack_words[lsp_pkg::ADDR_W'(level)];
            end
         end
         lsp_pkg::CMD_PEEK: begin
            // depth 1 is the top entry; zero is out of range too
            if (depth == 0 || int'(depth) > level) begin
               reply.status = lsp_pkg::ST_RANGE;
               reply.read_data = lsp_pkg::ERR_WORD;
            end else begin
               reply.read_data = stack_words[lsp_pkg::ADDR_W'(level - depth)];
            end
         end
         default: ;
      endcase
      reply.empty_flag = (level == 0);
      reply.full_flag = (level >= lsp_pkg::DEPTH);
      return reply;
   endfunction

   always @(posedge clock) begin
      stack_reply_type want;
      if (reset) begin
         level = 0;
         pending_replies.delete();
      end else begin
         // a response taken at this edge belongs to an earlier request
         if (rsp.valid && rsp.ready) begin
            if (pending_replies.size() == 0) begin
               $error("response with no request pending: read_data %0d status %0d",
                      rsp.read_data, rsp.status);
               fail_tally++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp.read_data !== want.read_data) begin
                  $error("read_data: expected %0d, got %0d", want.read_data, rsp.read_data);
                  fail_tally++;
               end
               if (rsp.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp.status);
                  fail_tally++;
               end
               if (rsp.empty_flag !== want.empty_flag) begin
                  $error("empty_flag: expected %0b, got %0b", want.empty_flag, rsp.empty_flag);
                  fail_tally++;
               end
               if (rsp.full_flag !== want.full_flag) begin
                  $error("full_flag: expected %0b, got %0b", want.full_flag, rsp.full_flag);
                  fail_tally++;
               end
            end
         end
         if (req.valid && req.ready) begin
            pending_replies.push_back(apply_command(req.command, req.push_value,
                                                    req.peek_depth));
         end
      end
      error_count <= fail_tally;
      outstanding <= pending_replies.size();
   end

endmodule

[tb/tb_top.sv]
module tb_top;

   localparam int ITEM_TARGET = 900;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic [lsp_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam lsp_pkg::word_type WORD_MIN = {1'b1, {(lsp_pkg::WORD_W-1){1'b0}}};
   localparam lsp_pkg::word_type WORD_MAX = {1'b0, {(lsp_pkg::WORD_W-1){1'b1}}};

   logic clock;
   logic reset;
   int error_count;
   int outstanding;
   int unsigned cycle_count = 0;
   int unsigned ready_hold = 0;
   int unsigned stack_level = 0;  // rough level, only to steer peek depths

   lsp_req_if req_if();
   lsp_rsp_if rsp_if();

   lifo_stack_with_peek u_dut (
      .clock,
      .reset,
      .req_if,
      .rsp_if
   );

   lsp_checker u_checker (
      .clock,
      .reset,
      .req(req_if),
      .rsp(rsp_if),
      .error_count,
      .outstanding
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   function automatic lsp_pkg::word_type random_word();
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 3))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            default: return -1;
         endcase
      end
      return $urandom;
   endfunction

   // back-pressure holds start only while bit 7 of the cycle count is set
   always @(posedge clock) begin
      if (reset) begin
         ready_hold <= 0;
         rsp_if.ready <= 1'b0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if (cycle_count[7] && $urandom_range(0, 3) == 0) ready_hold <= pick_gap();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_request(logic [lsp_pkg::CMD_W-1:0] command, lsp_pkg::word_type value,
                               logic [lsp_pkg::PEEK_W-1:0] depth);
      req_if.command <= command;
      req_if.push_value <= value;
      req_if.peek_depth <= depth;
      req_if.valid <= 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (command == lsp_pkg::CMD_PUSH && stack_level < lsp_pkg::DEPTH) stack_level++;
      if (command == lsp_pkg::CMD_POP && stack_level > 0) stack_level--;
   endtask

   task automatic idle_sender(int unsigned cycles);
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_replies();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned push_share;
      int unsigned roll;
      int unsigned sel;
      bit gappy;
      logic [lsp_pkg::CMD_W-1:0] command;
      logic [lsp_pkg::PEEK_W-1:0] depth;

      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.command <= lsp_pkg::CMD_PUSH;
      req_if.push_value <= '0;
      req_if.peek_depth <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty stack corners
      send_request(lsp_pkg::CMD_POP, '0, lsp_pkg::PEEK_W'(0));
      send_request(lsp_pkg::CMD_PEEK, '0, lsp_pkg::PEEK_W'(0));
      send_request(CMD_SPARE, WORD_MAX, lsp_pkg::PEEK_W'(1));
      send_request(lsp_pkg::CMD_PUSH, WORD_MIN, lsp_pkg::PEEK_W'(0));
      send_request(lsp_pkg::CMD_PUSH, WORD_MAX, lsp_pkg::PEEK_W'(0));
      send_request(lsp_pkg::CMD_PEEK, '0, lsp_pkg::PEEK_W'(1));
      send_request(lsp_pkg::CMD_PEEK, '0, lsp_pkg::PEEK_W'(2));
      send_request(lsp_pkg::CMD_PEEK, '0, lsp_pkg::PEEK_W'(3));
      send_request(lsp_pkg::CMD_PEEK, '0, lsp_pkg::PEEK_W'(0));
      send_request(lsp_pkg::CMD_POP, '0, lsp_pkg::PEEK_W'(0));
      // fill up, then push into a full stack
      for (int i = 0; i < lsp_pkg::DEPTH - 1; i++) begin
         send_request(lsp_pkg::CMD_PUSH, (i == 0) ? -1 : (i == 1) ? 0 : random_word(),
                      lsp_pkg::PEEK_W'(0));
      end
      send_request(lsp_pkg::CMD_PUSH, random_word(), lsp_pkg::PEEK_W'(0));
      send_request(lsp_pkg::CMD_PEEK, '0, lsp_pkg::PEEK_W'(lsp_pkg::DEPTH));
      send_request(lsp_pkg::CMD_PEEK, '0, {lsp_pkg::PEEK_W{1'b1}});
      drain_replies();

      push_share = 50;
      gappy = 1'b0;
      for (int n = 0; n < ITEM_TARGET; n++) begin
         // swing the push share so the stack sweeps between empty and full
         if (n % 60 == 0) begin
            case ($urandom_range(0, 2))
               0: push_share = 80;
               1: push_share = 50;
               default: push_share = 20;
            endcase
         end
         if (n % 100 == 0) gappy = ($urandom_range(0, 2) != 0);
         if (n == ITEM_TARGET / 2) drain_replies();

         roll = $urandom_range(0, 99);
         if (roll < push_share) command = lsp_pkg::CMD_PUSH;
         else if (roll >= 96) command = CMD_SPARE;
         else if ($urandom_range(0, 1) == 0) command = lsp_pkg::CMD_POP;
         else command = lsp_pkg::CMD_PEEK;

         sel = $urandom_range(0, 9);
         if (sel < 7) begin
            depth = lsp_pkg::PEEK_W'($urandom_range(1, (stack_level == 0) ? 1 : stack_level));
         end else if (sel < 8) begin
            depth = lsp_pkg::PEEK_W'(stack_level + 1);
         end else if (sel < 9) begin
            depth = '0;
         end else begin
            depth = lsp_pkg::PEEK_W'($urandom_range(0, 31));
         end

         send_request(command, random_word(), depth);
         if (gappy && $urandom_range(0, 2) == 0) idle_sender(pick_gap());
      end

      drain_replies();
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
